// ----- rtl/preemptive_lifo_job_scheduler_core_macros.svh -----
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_LIFO_JOB_SCHEDULER_CORE_MACROS_SVH
`define PREEMPTIVE_LIFO_JOB_SCHEDULER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLSCH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/plsch_pkg.sv -----
// ----------------------------------------------------------------------------
// plsch_pkg
// Types and constants shared by the LIFO job scheduler modules.
// ----------------------------------------------------------------------------
package plsch_pkg;

  localparam int ID_W       = 8;
  localparam int TIME_W     = 32;
  localparam int ERR_W      = 2;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;

  typedef enum logic {
    ACT_ARRIVE   = 1'b0,
    ACT_COMPLETE = 1'b1
  } action_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_code_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic              cancel_previous;
    logic              schedule_valid;
    logic [TIME_W-1:0] completion_time;
    logic              done_valid;
    logic [ID_W-1:0]   done_job_id;
    err_code_t         error_code;
  } result_t;

endpackage

// ----- rtl/plsch_ctrl.sv -----
// ----------------------------------------------------------------------------
// plsch_ctrl
// Request sequencing: accept, execute, and output register handshake.
// ----------------------------------------------------------------------------
module plsch_ctrl
  import plsch_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    in_tready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The result may only land once the output register is free or draining.
        cmd.commit = !out_valid_r || out_tready;
        if (cmd.commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- rtl/plsch_dp.sv -----
// ----------------------------------------------------------------------------
// plsch_dp
// Job stack, running-job registers, time arithmetic and result register.
// ----------------------------------------------------------------------------
module plsch_dp
  import plsch_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  action_t           in_action,
  input  logic [ID_W-1:0]   in_job_id,
  input  logic [TIME_W-1:0] in_job_length,
  input  logic [TIME_W-1:0] in_now,
  output result_t           res
);

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] rem;
  } entry_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  // The top job lives in registers; the memory holds the jobs beneath it.
  entry_t mem [STACK_DEPTH];

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] run_start_r, run_start_nxt;
  logic [ID_W-1:0]   top_id_r, top_id_nxt;
  logic [TIME_W-1:0] top_rem_r, top_rem_nxt;
  action_t           act_r;
  logic [ID_W-1:0]   id_in_r;
  logic [TIME_W-1:0] len_in_r;
  logic [TIME_W-1:0] now_in_r;
  logic [TIME_W-1:0] elapsed_r;
  entry_t            rd_data_r;
  result_t           res_r, res_nxt;

  logic [CNT_W-1:0]  rd_cnt;
  logic [CNT_W-1:0]  wr_cnt;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  wr_idx;
  logic              wr_en;
  entry_t            wr_data;

  assign rd_cnt = cnt_r - CNT_W'(2);
  assign wr_cnt = cnt_r - CNT_W'(1);
  assign rd_idx = rd_cnt[IDX_W-1:0];
  assign wr_idx = wr_cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      run_start_r <= '0;
    end else if (cmd.commit) begin
      cnt_r       <= cnt_nxt;
      run_start_r <= run_start_nxt;
    end
  end

  // Accept cycle: capture the request, the elapsed run time and the entry
  // that becomes the top on a pop.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r     <= in_action;
      id_in_r   <= in_job_id;
      len_in_r  <= in_job_length;
      now_in_r  <= in_now;
      elapsed_r <= sat_sub(in_now, run_start_r);
      rd_data_r <= mem[rd_idx];
    end
    if (cmd.commit) begin
      top_id_r  <= top_id_nxt;
      top_rem_r <= top_rem_nxt;
      res_r     <= res_nxt;
      if (wr_en) begin
        mem[wr_idx] <= wr_data;
      end
    end
  end

  always_comb begin
    res_nxt       = '0;
    cnt_nxt       = cnt_r;
    run_start_nxt = run_start_r;
    top_id_nxt    = top_id_r;
    top_rem_nxt   = top_rem_r;
    wr_en         = 1'b0;
    wr_data.id    = top_id_r;
    wr_data.rem   = sat_sub(top_rem_r, elapsed_r);
    case (act_r)
      ACT_ARRIVE: begin
        if (cnt_r == CNT_W'(STACK_DEPTH)) begin
          res_nxt.error_code = ERR_FULL;
        end else begin
          if (cnt_r != '0) begin
            // Preempt: the running job goes below with its time reduced.
            wr_en                   = 1'b1;
            res_nxt.cancel_previous = 1'b1;
          end
          top_id_nxt              = id_in_r;
          top_rem_nxt             = len_in_r;
          cnt_nxt                 = cnt_r + CNT_W'(1);
          run_start_nxt           = now_in_r;
          res_nxt.schedule_valid  = 1'b1;
          res_nxt.completion_time = sat_add(now_in_r, len_in_r);
        end
      end
      ACT_COMPLETE: begin
        if (cnt_r == '0) begin
          res_nxt.error_code = ERR_EMPTY;
        end else begin
          cnt_nxt             = wr_cnt;
          res_nxt.done_valid  = 1'b1;
          res_nxt.done_job_id = top_id_r;
          if (cnt_r > CNT_W'(1)) begin
            top_id_nxt              = rd_data_r.id;
            top_rem_nxt             = rd_data_r.rem;
            run_start_nxt           = now_in_r;
            res_nxt.schedule_valid  = 1'b1;
            res_nxt.completion_time = sat_add(now_in_r, rd_data_r.rem);
          end
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  assign res = res_r;

endmodule

// ----- rtl/preemptive_lifo_job_scheduler_core.sv -----
// Preemptive last-come-first-served job scheduler. Each request passes an
// accept step and then an execute step: in the accept step the request is
// registered, the elapsed run time of the current job is computed and the
// stack memory is read for the job beneath the top; in the execute step the
// stack and timing state are updated and the result is loaded into the
// output register. The execute step waits while a previous result is still
// held on the output. The running job is kept in registers, the memory has a
// single read port; no new request is accepted before the execute step ends.
// ----------------------------------------------------------------------------
// preemptive_lifo_job_scheduler_core
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
`include "preemptive_lifo_job_scheduler_core_macros.svh"

module preemptive_lifo_job_scheduler_core
  import plsch_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // job_id[7:0], job_length[39:8], now[71:40]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cancel_previous[0], schedule_valid[1], completion_time[33:2],
  // done_valid[34], done_job_id[42:35], error_code[44:43], zero[47:45]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  dp_cmd_t cmd;
  result_t res;

  plsch_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  plsch_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_action     (action_t'(in_tuser)),
    .in_job_id     (in_tdata[7:0]),
    .in_job_length (in_tdata[39:8]),
    .in_now        (in_tdata[71:40]),
    .res           (res)
  );

  assign out_tdata = {3'b000, res.error_code, res.done_job_id, res.done_valid,
                      res.completion_time, res.schedule_valid,
                      res.cancel_previous};

  `PLSCH_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
    "scheduler accepted a request while the previous one was executing")

  `PLSCH_ASSERT_SAME(a_error_clean, out_tvalid && res.error_code != ERR_NONE,
    !res.schedule_valid && !res.done_valid && !res.cancel_previous,
    "error result carries scheduling or completion fields")

  `PLSCH_ASSERT_SAME(a_unscheduled_zero, out_tvalid && !res.schedule_valid,
    res.completion_time == '0,
    "completion time nonzero without a scheduled completion")

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives arrival and completion requests into the LIFO job scheduler. The
// sender uses bursty timing and the receiver uses a changing stall pattern.
// A scoreboard tracks its own copy of the job stack and checks every result
// field against what the stack predicts.
// ----------------------------------------------------------------------------
module testbench;
  import plsch_pkg::*;

  localparam int JOB_SLOTS       = 16;
  localparam int RANDOM_REQUESTS = 476;

  class sched_scoreboard;
    result_t             pending_results[$];
    logic [ID_W-1:0]     job_ids [JOB_SLOTS];
    logic [TIME_W-1:0]   job_left [JOB_SLOTS];
    int                  jobs_held;
    logic [TIME_W-1:0]   run_start;
    int                  mismatches;
    int                  requests_seen;
    int                  results_seen;
    int                  peak_depth;
    int                  full_rejects;
    int                  empty_rejects;
    int                  saturated;

    function new();
      jobs_held     = 0;
      run_start     = '0;
      mismatches    = 0;
      requests_seen = 0;
      results_seen  = 0;
      peak_depth    = 0;
      full_rejects  = 0;
      empty_rejects = 0;
      saturated     = 0;
    endfunction

    function logic [TIME_W-1:0] add_clamped(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum[TIME_W]) begin
        saturated++;
        return '1;
      end
      return sum[TIME_W-1:0];
    endfunction

    function logic [TIME_W-1:0] sub_floor(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      return (a > b) ? a - b : '0;
    endfunction

    // Works out the result of one accepted request and updates the stack.
    function void note_request(action_t act, logic [ID_W-1:0] id,
                               logic [TIME_W-1:0] len, logic [TIME_W-1:0] t);
      result_t          r;
      logic [TIME_W-1:0] elapsed;
      r = '0;
      requests_seen++;
      if (act == ACT_ARRIVE) begin
        if (jobs_held >= JOB_SLOTS) begin
          r.error_code = ERR_FULL;
          full_rejects++;
        end else begin
          if (jobs_held > 0) begin
            // The preempted job loses the time it ran since it last started.
            elapsed = sub_floor(t, run_start);
            job_left[jobs_held-1] = sub_floor(job_left[jobs_held-1], elapsed);
            r.cancel_previous = 1'b1;
          end
          job_ids[jobs_held]  = id;
          job_left[jobs_held] = len;
          jobs_held++;
          run_start = t;
          r.schedule_valid  = 1'b1;
          r.completion_time = add_clamped(t, len);
          if (jobs_held > peak_depth) peak_depth = jobs_held;
        end
      end else begin
        if (jobs_held == 0) begin
          r.error_code = ERR_EMPTY;
          empty_rejects++;
        end else begin
          jobs_held--;
          r.done_valid  = 1'b1;
          r.done_job_id = job_ids[jobs_held];
          if (jobs_held > 0) begin
            run_start = t;
            r.schedule_valid  = 1'b1;
            r.completion_time = add_clamped(t, job_left[jobs_held-1]);
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    function int report_field(string what, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (want === got) return 0;
      if (mismatches < 10)
        $display("  result %0d: %s expected 0x%0h, got 0x%0h", results_seen, what, want, got);
      return 1;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] raw);
      result_t got;
      result_t want;
      int      bad;
      got.cancel_previous = raw[0];
      got.schedule_valid  = raw[1];
      got.completion_time = raw[33:2];
      got.done_valid      = raw[34];
      got.done_job_id     = raw[42:35];
      got.error_code      = err_code_t'(raw[44:43]);
      results_seen++;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("  result %0d arrived with no request outstanding: 0x%0h",
                   results_seen, raw);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      bad = 0;
      bad += report_field("cancel_previous", TIME_W'(want.cancel_previous),
                          TIME_W'(got.cancel_previous));
      bad += report_field("schedule_valid", TIME_W'(want.schedule_valid),
                          TIME_W'(got.schedule_valid));
      bad += report_field("completion_time", want.completion_time, got.completion_time);
      bad += report_field("done_valid", TIME_W'(want.done_valid), TIME_W'(got.done_valid));
      bad += report_field("done_job_id", TIME_W'(want.done_job_id), TIME_W'(got.done_job_id));
      bad += report_field("error_code", TIME_W'(want.error_code), TIME_W'(got.error_code));
      bad += report_field("padding", '0, TIME_W'(raw[OUT_DATA_W-1:45]));
      if (bad != 0) mismatches++;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  sched_scoreboard sb;
  int              burst_left = 0;
  int              items_sent = 0;
  int              stall_mode = 0;
  int unsigned     rx_tick = 0;
  logic [TIME_W-1:0] sim_now = '0;

  preemptive_lifo_job_scheduler_core #(
    .STACK_DEPTH(JOB_SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls follow a stall mode that is redrawn at random.
  always @(posedge clk) begin
    if (rx_tick % 128 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= (rx_tick % 4 == 0);
      end
      default: begin
        out_tready <= (rx_tick % 32) >= 24;
      end
    endcase
    rx_tick++;
  end

  // Results are checked before a request at the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready)
        sb.note_request(action_t'(in_tuser), in_tdata[7:0], in_tdata[39:8], in_tdata[71:40]);
    end
  end

  task automatic issue(action_t act, logic [ID_W-1:0] id, logic [TIME_W-1:0] len,
                       logic [TIME_W-1:0] t);
    int idle_cycles;
    if (burst_left == 0) begin
      idle_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (idle_cycles > 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= {$urandom, $urandom, 8'($urandom)};
        repeat (idle_cycles) @(posedge clk);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {t, len, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  initial begin
    int                push_pct;
    int                roll;
    action_t           act;
    logic [TIME_W-1:0] len;
    logic [TIME_W-1:0] t;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty completion, saturation, time going backward,
    // elapsed time beyond the remaining time, draining to empty, then a
    // full stack followed by a rejected arrival.
    issue(ACT_COMPLETE, 8'h3c, 32'h0, 32'h0);
    issue(ACT_ARRIVE, 8'hff, 32'hffff_ffff, 32'd100);
    issue(ACT_ARRIVE, 8'h00, 32'd1000, 32'd50);
    issue(ACT_ARRIVE, 8'ha5, 32'h10, 32'hffff_fff0);
    issue(ACT_COMPLETE, 8'h00, 32'h0, 32'hffff_ffff);
    issue(ACT_COMPLETE, 8'h5a, 32'hffff_ffff, 32'd200);
    issue(ACT_COMPLETE, 8'h00, 32'h0, 32'd210);
    for (int i = 0; i < JOB_SLOTS; i++)
      issue(ACT_ARRIVE, 8'(i + 1), 32'(i * 3), 32'(300 + i));
    issue(ACT_ARRIVE, 8'h77, 32'd5, 32'd320);
    sim_now = 32'd400;

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // The push bias shifts so the stack swings between empty and full.
      if (n % 25 == 0) begin
        roll = $urandom_range(0, 2);
        push_pct = (roll == 0) ? 15 : (roll == 1) ? 50 : 85;
      end
      act = ($urandom_range(0, 99) < push_pct) ? ACT_ARRIVE : ACT_COMPLETE;
      roll = $urandom_range(0, 99);
      if (roll < 5) sim_now = $urandom;
      else if (roll < 10) sim_now = sim_now - $urandom_range(1, 40);
      else sim_now = sim_now + $urandom_range(0, 60);
      t = sim_now;
      roll = $urandom_range(0, 99);
      if (roll < 60) len = $urandom_range(0, 100);
      else if (roll < 75) len = $urandom_range(101, 5000);
      else if (roll < 85) len = $urandom;
      else if (roll < 95) len = 32'hffff_ffff - $urandom_range(0, 100);
      else len = '0;
      issue(act, 8'($urandom_range(0, 255)), len, t);
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d requests and checked %0d results; deepest stack %0d of %0d.",
             items_sent, sb.results_seen, sb.peak_depth, JOB_SLOTS);
    $display("Full rejections %0d, empty completions %0d, saturated times %0d, mismatches %0d.",
             sb.full_rejects, sb.empty_rejects, sb.saturated, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d results still expected.", sb.pending());
    $display("testbench: errors");
    $finish;
  end

endmodule

// ----- preemptive_lifo_job_scheduler_core.f -----
+incdir+rtl
rtl/plsch_pkg.sv
rtl/plsch_ctrl.sv
rtl/plsch_dp.sv
rtl/preemptive_lifo_job_scheduler_core.sv
sim/testbench.sv
